### rtl/core/gaussian_color_pixel_classifier_macros.svh
// Assertion macros used by the classifier top level.
`ifndef GAUSSIAN_COLOR_PIXEL_CLASSIFIER_MACROS_SVH
`define GAUSSIAN_COLOR_PIXEL_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS
`define GCPC_CHECK(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("classifier check failed");
`define GCPC_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("classifier check failed");
`else
`define GCPC_CHECK(label, ante, cons)
`define GCPC_CHECK_NEXT(label, ante, cons)
`endif

`endif

### rtl/core/gcpc_pkg.sv
// Types and constants of the Gaussian color pixel classifier.
package gcpc_pkg;

    typedef enum logic [2:0] {
        CFG_LIGHT_MEAN,
        CFG_LIGHT_SPREAD,
        CFG_CHROMA_A_MEAN,
        CFG_CHROMA_A_SPREAD,
        CFG_CHROMA_B_MEAN,
        CFG_CHROMA_B_SPREAD,
        CFG_MASK_RATIO
    } t_cfg_idx;

    typedef logic [16:0] t_lik;

    localparam logic [11:0] RST_LIGHT_MEAN      = 12'd3520;
    localparam logic [11:0] RST_LIGHT_SPREAD    = 12'd480;
    localparam logic [11:0] RST_CHROMA_A_MEAN   = 12'd2048;
    localparam logic [11:0] RST_CHROMA_A_SPREAD = 12'd160;
    localparam logic [11:0] RST_CHROMA_B_MEAN   = 12'd2048;
    localparam logic [11:0] RST_CHROMA_B_SPREAD = 12'd160;
    localparam logic [10:0] RST_MASK_RATIO      = 11'd358;
    localparam logic [10:0] RATIO_ONE           = 11'd1024;

    localparam int unsigned QUOT_W       = 24;
    localparam int unsigned DIV_STEPS    = 4;
    localparam int unsigned DIV_STAGES   = QUOT_W / DIV_STEPS;
    localparam int unsigned SERIES_TERMS = 10;
    localparam int unsigned SQUARINGS    = 4;

    // Smallest normalized delta whose half square reaches the cutoff of 12.
    localparam logic [23:0] CUTOFF_M = 24'd20067;
    localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
    localparam logic [30:0] E_ROUND  = 31'd8192;

    // Exact floor division by k as a multiply by ceil(2^RSHIFT/k), inputs below 2^30.
    localparam int unsigned RSHIFT [2:SERIES_TERMS] = '{31, 32, 32, 33, 33, 33, 33, 34, 34};
    localparam logic [31:0] RECIP [2:SERIES_TERMS] = '{
        32'(((64'd1 << 31) + 64'd1) / 64'd2),
        32'(((64'd1 << 32) + 64'd2) / 64'd3),
        32'(((64'd1 << 32) + 64'd3) / 64'd4),
        32'(((64'd1 << 33) + 64'd4) / 64'd5),
        32'(((64'd1 << 33) + 64'd5) / 64'd6),
        32'(((64'd1 << 33) + 64'd6) / 64'd7),
        32'(((64'd1 << 33) + 64'd7) / 64'd8),
        32'(((64'd1 << 34) + 64'd8) / 64'd9),
        32'(((64'd1 << 34) + 64'd9) / 64'd10)
    };

    localparam int unsigned CH_LAT   = 1 + DIV_STAGES + 1 + 2 * (SERIES_TERMS - 1) + 1
                                       + SQUARINGS + 1;
    localparam int unsigned PIPE_LAT = CH_LAT + 3;

endpackage

### rtl/core/gcpc_channel.sv
// Pipelined Gaussian likelihood of one color channel in Q1.16.
module gcpc_channel (
    input  logic               i_clk,
    input  logic [7:0]         i_value,
    input  logic [11:0]        i_mean,
    input  logic [11:0]        i_spread,
    output gcpc_pkg::t_lik     o_lik
);

    localparam int unsigned NDS = gcpc_pkg::DIV_STAGES;
    localparam int unsigned NT  = gcpc_pkg::SERIES_TERMS;
    localparam int unsigned NSQ = gcpc_pkg::SQUARINGS;

    logic [11:0] w_scaled;
    logic [11:0] r_mag;
    logic [11:0] r_sig;

    logic [11:0] r_qrem [NDS];
    logic [23:0] r_qquo [NDS];
    logic [11:0] r_qmag [NDS];
    logic [11:0] r_qsig [NDS];

    logic        w_big;
    logic [14:0] w_m;
    logic [29:0] w_msq_full;
    logic [28:0] r_msq;
    logic        r_msq_zero;
    logic [29:0] w_y;

    logic [59:0]        r_mprod [2:NT];
    logic [29:0]        r_my    [2:NT];
    logic signed [31:0] r_macc  [2:NT];
    logic               r_mz    [2:NT];
    logic [61:0]        r_dprod [2:NT];
    logic [29:0]        r_dy    [2:NT];
    logic signed [31:0] r_dacc  [2:NT];
    logic               r_dz    [2:NT];

    logic [29:0]        w_term_last;
    logic signed [31:0] w_acc_last;
    logic [30:0]        r_s0;
    logic               r_s0_zero;

    logic [60:0] r_sq   [NSQ];
    logic        r_sq_z [NSQ];

    logic [30:0] w_s_last;
    logic [30:0] w_round;
    gcpc_pkg::t_lik r_lik;

    assign w_scaled = {i_value, 4'b0000};

    always_ff @(posedge i_clk) begin
        r_mag <= (w_scaled >= i_mean) ? (w_scaled - i_mean) : (i_mean - w_scaled);
        r_sig <= (i_spread == 12'd0) ? 12'd1 : i_spread;
    end

    for (genvar g = 0; g < NDS; g++) begin : g_div
        logic [11:0] rem_in;
        logic [23:0] quo_in;
        logic [11:0] mag_in;
        logic [11:0] sig_in;
        logic [23:0] num_in;
        logic [11:0] rem_out;
        logic [23:0] quo_out;

        if (g == 0) begin : g_first
            assign rem_in = 12'd0;
            assign quo_in = 24'd0;
            assign mag_in = r_mag;
            assign sig_in = r_sig;
        end else begin : g_next
            assign rem_in = r_qrem[g-1];
            assign quo_in = r_qquo[g-1];
            assign mag_in = r_qmag[g-1];
            assign sig_in = r_qsig[g-1];
        end

        assign num_in = {mag_in, 12'd0};

        always_comb begin
            logic [12:0] trial;
            rem_out = rem_in;
            quo_out = quo_in;
            for (int j = 0; j < int'(gcpc_pkg::DIV_STEPS); j++) begin
                trial = {rem_out, num_in[gcpc_pkg::QUOT_W - 1 - (g * gcpc_pkg::DIV_STEPS + j)]};
                if (trial >= {1'b0, sig_in}) begin
                    rem_out = 12'(trial - {1'b0, sig_in});
                    quo_out = {quo_out[22:0], 1'b1};
                end else begin
                    rem_out = trial[11:0];
                    quo_out = {quo_out[22:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_qrem[g] <= rem_out;
            r_qquo[g] <= quo_out;
            r_qmag[g] <= mag_in;
            r_qsig[g] <= sig_in;
        end
    end

    assign w_big      = (r_qquo[NDS-1] >= gcpc_pkg::CUTOFF_M);
    assign w_m        = w_big ? 15'd0 : r_qquo[NDS-1][14:0];
    assign w_msq_full = w_m * w_m;

    always_ff @(posedge i_clk) begin
        r_msq      <= w_msq_full[28:0];
        r_msq_zero <= w_big;
    end

    assign w_y = {r_msq, 1'b0};

    for (genvar k = 2; k <= NT; k++) begin : g_term
        logic [29:0]        term_in;
        logic [29:0]        y_in;
        logic signed [31:0] acc_in;
        logic               z_in;
        logic [59:0]        mprod;
        logic [61:0]        dprod;

        if (k == 2) begin : g_first
            assign term_in = w_y;
            assign y_in    = w_y;
            assign acc_in  = $signed({1'b0, gcpc_pkg::Q30_ONE}) - $signed({2'b00, w_y});
            assign z_in    = r_msq_zero;
        end else begin : g_next
            assign term_in = 30'(r_dprod[k-1] >> gcpc_pkg::RSHIFT[k-1]);
            assign y_in    = r_dy[k-1];
            assign z_in    = r_dz[k-1];
            if (((k - 1) % 2) == 1) begin : g_sub
                assign acc_in = r_dacc[k-1] - $signed({2'b00, term_in});
            end else begin : g_add
                assign acc_in = r_dacc[k-1] + $signed({2'b00, term_in});
            end
        end

        assign mprod = term_in * y_in;
        assign dprod = r_mprod[k][59:30] * gcpc_pkg::RECIP[k];

        always_ff @(posedge i_clk) begin
            r_mprod[k] <= mprod;
            r_my[k]    <= y_in;
            r_macc[k]  <= acc_in;
            r_mz[k]    <= z_in;
            r_dprod[k] <= dprod;
            r_dy[k]    <= r_my[k];
            r_dacc[k]  <= r_macc[k];
            r_dz[k]    <= r_mz[k];
        end
    end

    assign w_term_last = 30'(r_dprod[NT] >> gcpc_pkg::RSHIFT[NT]);
    assign w_acc_last  = ((NT % 2) == 1) ? (r_dacc[NT] - $signed({2'b00, w_term_last}))
                                         : (r_dacc[NT] + $signed({2'b00, w_term_last}));

    always_ff @(posedge i_clk) begin
        r_s0_zero <= r_dz[NT];
        priority if (w_acc_last < 32'sd0) begin
            r_s0 <= 31'd0;
        end else if (w_acc_last > $signed({1'b0, gcpc_pkg::Q30_ONE})) begin
            r_s0 <= gcpc_pkg::Q30_ONE;
        end else begin
            r_s0 <= w_acc_last[30:0];
        end
    end

    for (genvar j = 0; j < NSQ; j++) begin : g_sq
        logic [30:0] s_in;
        logic        z_in;
        logic [61:0] sq_full;

        if (j == 0) begin : g_first
            assign s_in = r_s0;
            assign z_in = r_s0_zero;
        end else begin : g_next
            assign s_in = r_sq[j-1][60:30];
            assign z_in = r_sq_z[j-1];
        end

        assign sq_full = s_in * s_in;

        always_ff @(posedge i_clk) begin
            r_sq[j]   <= sq_full[60:0];
            r_sq_z[j] <= z_in;
        end
    end

    assign w_s_last = r_sq[NSQ-1][60:30];
    assign w_round  = w_s_last + gcpc_pkg::E_ROUND;

    always_ff @(posedge i_clk) begin
        r_lik <= r_sq_z[NSQ-1] ? 17'd0 : w_round[30:14];
    end

    assign o_lik = r_lik;

endmodule

### rtl/core/gaussian_color_pixel_classifier.sv
// Top level of the Gaussian color pixel classifier: configuration, valid line, product and mask.
//
// A pixel beat (lightness, a and b bytes) is taken at a rising edge where start is high
// and busy is low. busy is high only while reset is asserted, so one pixel can enter in
// every clock cycle and the rate is one pixel per cycle.
// The result beat (likelihood byte and mask bit) appears on the outputs for one cycle
// with o_valid high and is taken at the rising edge that ends that cycle. The depth is
// set by the input register, the six stage delta divider, the square register, the two
// multiplier stages per exp series term after the first, the clamp register, the four
// squaring stages and the output register in each channel, plus three stages for the
// product and the mask. The receiver cannot stall; every beat is delivered exactly once.
// Configuration registers are written through i_cfg_we, i_cfg_idx and i_cfg_data and
// must change only while no pixel is in flight. Unknown indexes are ignored.
// Synchronous reset loads the default means, spreads and mask ratio and clears the
// valid line, so no result beat comes out until a new pixel is taken.
`include "gaussian_color_pixel_classifier_macros.svh"

module gaussian_color_pixel_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_light_value,
    input  logic [7:0]  i_chroma_a_value,
    input  logic [7:0]  i_chroma_b_value,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_data,
    output logic        o_valid,
    output logic [7:0]  o_white_likelihood,
    output logic        o_white_mask
);

    localparam int unsigned PL = gcpc_pkg::PIPE_LAT;

    logic [11:0] r_light_mean;
    logic [11:0] r_light_spread;
    logic [11:0] r_chroma_a_mean;
    logic [11:0] r_chroma_a_spread;
    logic [11:0] r_chroma_b_mean;
    logic [11:0] r_chroma_b_spread;
    logic [10:0] r_mask_ratio;

    logic [PL-1:0]  r_valid;
    logic [PL-1:0]  n_valid;
    gcpc_pkg::t_lik w_lik [3];

    logic [33:0]    w_p1;
    logic [32:0]    r_p1;
    gcpc_pkg::t_lik r_eb;
    logic [49:0]    w_p;
    logic [48:0]    r_p;
    logic [56:0]    w_p255;
    logic [7:0]     w_byte;
    logic [10:0]    w_ratio;
    logic [18:0]    w_thr;
    logic [7:0]     r_byte;
    logic           r_mask;

    assign busy = ~i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_mean      <= gcpc_pkg::RST_LIGHT_MEAN;
            r_light_spread    <= gcpc_pkg::RST_LIGHT_SPREAD;
            r_chroma_a_mean   <= gcpc_pkg::RST_CHROMA_A_MEAN;
            r_chroma_a_spread <= gcpc_pkg::RST_CHROMA_A_SPREAD;
            r_chroma_b_mean   <= gcpc_pkg::RST_CHROMA_B_MEAN;
            r_chroma_b_spread <= gcpc_pkg::RST_CHROMA_B_SPREAD;
            r_mask_ratio      <= gcpc_pkg::RST_MASK_RATIO;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gcpc_pkg::CFG_LIGHT_MEAN:      r_light_mean      <= i_cfg_data;
                gcpc_pkg::CFG_LIGHT_SPREAD:    r_light_spread    <= i_cfg_data;
                gcpc_pkg::CFG_CHROMA_A_MEAN:   r_chroma_a_mean   <= i_cfg_data;
                gcpc_pkg::CFG_CHROMA_A_SPREAD: r_chroma_a_spread <= i_cfg_data;
                gcpc_pkg::CFG_CHROMA_B_MEAN:   r_chroma_b_mean   <= i_cfg_data;
                gcpc_pkg::CFG_CHROMA_B_SPREAD: r_chroma_b_spread <= i_cfg_data;
                gcpc_pkg::CFG_MASK_RATIO:      r_mask_ratio      <= i_cfg_data[10:0];
                default: begin
                end
            endcase
        end
    end

    assign n_valid = {r_valid[PL-2:0], start & ~busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    gcpc_channel u_light (
        .i_clk    (i_clk),
        .i_value  (i_light_value),
        .i_mean   (r_light_mean),
        .i_spread (r_light_spread),
        .o_lik    (w_lik[0])
    );

    gcpc_channel u_chroma_a (
        .i_clk    (i_clk),
        .i_value  (i_chroma_a_value),
        .i_mean   (r_chroma_a_mean),
        .i_spread (r_chroma_a_spread),
        .o_lik    (w_lik[1])
    );

    gcpc_channel u_chroma_b (
        .i_clk    (i_clk),
        .i_value  (i_chroma_b_value),
        .i_mean   (r_chroma_b_mean),
        .i_spread (r_chroma_b_spread),
        .o_lik    (w_lik[2])
    );

    assign w_p1 = w_lik[0] * w_lik[1];
    assign w_p  = r_p1 * r_eb;

    // The product is at most 2^48, so the scaled byte never exceeds 255.
    assign w_p255  = {r_p, 8'd0} - {8'd0, r_p};
    assign w_byte  = w_p255[55:48];
    assign w_ratio = (r_mask_ratio > gcpc_pkg::RATIO_ONE) ? gcpc_pkg::RATIO_ONE : r_mask_ratio;
    assign w_thr   = {w_ratio, 8'd0} - {8'd0, w_ratio};

    always_ff @(posedge i_clk) begin
        r_p1   <= w_p1[32:0];
        r_eb   <= w_lik[2];
        r_p    <= w_p[48:0];
        r_byte <= w_byte;
        r_mask <= ({1'b0, w_byte, 10'd0} > w_thr);
    end

    assign o_valid            = r_valid[PL-1];
    assign o_white_likelihood = r_byte;
    assign o_white_mask       = r_mask;

    `GCPC_CHECK(a_accept_gives_result, start && !busy, ##PL o_valid)
    `GCPC_CHECK(a_result_had_accept, o_valid, $past(start && !busy, PL))
    `GCPC_CHECK(a_full_ratio_no_mask, $past(r_mask_ratio) >= gcpc_pkg::RATIO_ONE, !o_white_mask)
    `GCPC_CHECK_NEXT(a_zero_light_zero_out, w_lik[0] == 17'd0,
                     ##2 (o_white_likelihood == 8'd0 && !o_white_mask))

endmodule

### bench/gaussian_color_pixel_classifier_tb.sv
// Self-checking testbench of the Gaussian color pixel classifier with a bit-exact scoring model.
module gaussian_color_pixel_classifier_tb;

    localparam int PIXELS_PER_PHASE = 150;
    localparam int NUM_PHASES       = 8;
    localparam int STALL_LIMIT      = 1000;
    localparam int EXP_TERMS        = 10;
    localparam int EXP_SQUARINGS    = 4;
    localparam logic [2:0] CFG_NO_REG = 3'd7;

    typedef struct packed {
        logic [7:0] light;
        logic [7:0] chroma_a;
        logic [7:0] chroma_b;
    } t_pixel;

    typedef struct packed {
        logic [7:0] likelihood;
        logic       mask;
    } t_score;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [7:0]  i_light_value = 8'd0;
    logic [7:0]  i_chroma_a_value = 8'd0;
    logic [7:0]  i_chroma_b_value = 8'd0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = 3'd0;
    logic [11:0] i_cfg_data = 12'd0;
    logic        o_valid;
    logic [7:0]  o_white_likelihood;
    logic        o_white_mask;

    t_pixel      pixel_backlog[$];
    t_score      pending_scores[$];
    t_pixel      next_pixel;
    t_score      oldest_score;
    logic [11:0] chan_mean [0:2];
    logic [11:0] chan_spread [0:2];
    logic [10:0] ratio_setting;
    bit          steady = 1'b0;
    int          idle_left = 0;
    int          error_count = 0;
    int          stall_cycles = 0;

    gaussian_color_pixel_classifier i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_light_value      (i_light_value),
        .i_chroma_a_value   (i_chroma_a_value),
        .i_chroma_b_value   (i_chroma_b_value),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .o_valid            (o_valid),
        .o_white_likelihood (o_white_likelihood),
        .o_white_mask       (o_white_mask)
    );

    always #5 i_clk = ~i_clk;

    // Gaussian weight of one channel in Q1.16, where 65536 stands for one.
    function automatic gcpc_pkg::t_lik channel_weight(logic [7:0] v, logic [11:0] mean,
                                                      logic [11:0] spread);
        logic [63:0] scaled, offset_mag, divisor, nd, nd_sq, y, term, s;
        longint      acc;
        int          k;
        scaled = {52'd0, v, 4'd0};
        offset_mag = (scaled >= 64'(mean)) ? scaled - 64'(mean) : 64'(mean) - scaled;
        divisor = (spread == 12'd0) ? 64'd1 : 64'(spread);
        nd = (offset_mag << 12) / divisor;
        if (nd > 64'd65535) begin
            nd = 64'd65535;
        end
        nd_sq = nd * nd;
        if (nd_sq >= (64'd12 << 25)) begin
            return '0;
        end
        y = nd_sq * 64'd2;
        term = 64'd1 << 30;
        acc = longint'(term);
        for (k = 1; k <= EXP_TERMS; k++) begin
            term = ((term * y) >> 30) / 64'(k);
            if (k % 2 == 1) begin
                acc -= longint'(term);
            end else begin
                acc += longint'(term);
            end
        end
        s = (acc < 0) ? 64'd0 : 64'(acc);
        if (s > (64'd1 << 30)) begin
            s = 64'd1 << 30;
        end
        for (k = 0; k < EXP_SQUARINGS; k++) begin
            s = (s * s) >> 30;
        end
        s = (s + 64'd8192) >> 14;
        if (s > 64'd65536) begin
            s = 64'd65536;
        end
        return gcpc_pkg::t_lik'(s);
    endfunction

    function automatic t_score pixel_score(t_pixel px);
        logic [63:0] prod, level, ratio;
        t_score      score;
        prod = 64'(channel_weight(px.light, chan_mean[0], chan_spread[0]))
             * 64'(channel_weight(px.chroma_a, chan_mean[1], chan_spread[1]))
             * 64'(channel_weight(px.chroma_b, chan_mean[2], chan_spread[2]));
        level = (prod * 64'd255) >> 48;
        if (level > 64'd255) begin
            level = 64'd255;
        end
        ratio = (ratio_setting > 11'd1024) ? 64'd1024 : 64'(ratio_setting);
        score.likelihood = level[7:0];
        score.mask = (level * 64'd1024 > ratio * 64'd255);
        return score;
    endfunction

    // Mostly values within about three spreads of the mean, so that the product is not zero.
    function automatic logic [7:0] channel_pick(logic [11:0] mean, logic [11:0] spread);
        int center, reach, v;
        if ($urandom_range(0, 3) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        center = int'(mean >> 4);
        reach = ((int'(spread == 12'd0 ? 12'd1 : spread) * 3) >> 4) + 1;
        v = center - reach + int'($urandom_range(0, 2 * reach));
        if (v < 0) begin
            v = 0;
        end else if (v > 255) begin
            v = 255;
        end
        return 8'(v);
    endfunction

    function automatic logic [11:0] random_spread();
        if ($urandom_range(0, 1) == 0) begin
            return 12'($urandom_range(1, 4095));
        end
        return 12'($urandom_range(8, 800));
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    task automatic write_register(logic [2:0] idx, logic [11:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            gcpc_pkg::CFG_LIGHT_MEAN:      chan_mean[0] = data;
            gcpc_pkg::CFG_LIGHT_SPREAD:    chan_spread[0] = data;
            gcpc_pkg::CFG_CHROMA_A_MEAN:   chan_mean[1] = data;
            gcpc_pkg::CFG_CHROMA_A_SPREAD: chan_spread[1] = data;
            gcpc_pkg::CFG_CHROMA_B_MEAN:   chan_mean[2] = data;
            gcpc_pkg::CFG_CHROMA_B_SPREAD: chan_spread[2] = data;
            gcpc_pkg::CFG_MASK_RATIO:      ratio_setting = data[10:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [11:0] mean, logic [11:0] spread, logic [11:0] ratio);
        write_register(gcpc_pkg::CFG_LIGHT_MEAN, mean);
        write_register(gcpc_pkg::CFG_LIGHT_SPREAD, spread);
        write_register(gcpc_pkg::CFG_CHROMA_A_MEAN, mean);
        write_register(gcpc_pkg::CFG_CHROMA_A_SPREAD, spread);
        write_register(gcpc_pkg::CFG_CHROMA_B_MEAN, mean);
        write_register(gcpc_pkg::CFG_CHROMA_B_SPREAD, spread);
        write_register(gcpc_pkg::CFG_MASK_RATIO, ratio);
    endtask

    task automatic randomize_setup();
        write_register(gcpc_pkg::CFG_LIGHT_MEAN, 12'($urandom_range(0, 4095)));
        write_register(gcpc_pkg::CFG_LIGHT_SPREAD, random_spread());
        write_register(gcpc_pkg::CFG_CHROMA_A_MEAN, 12'($urandom_range(0, 4095)));
        write_register(gcpc_pkg::CFG_CHROMA_A_SPREAD, random_spread());
        write_register(gcpc_pkg::CFG_CHROMA_B_MEAN, 12'($urandom_range(0, 4095)));
        write_register(gcpc_pkg::CFG_CHROMA_B_SPREAD, random_spread());
        write_register(gcpc_pkg::CFG_MASK_RATIO, 12'($urandom_range(0, 1024)));
    endtask

    task automatic wait_for_drain();
        do begin
            @(negedge i_clk);
        end while (pixel_backlog.size() != 0 || start || pending_scores.size() != 0);
    endtask

    initial begin
        chan_mean[0] = gcpc_pkg::RST_LIGHT_MEAN;
        chan_spread[0] = gcpc_pkg::RST_LIGHT_SPREAD;
        chan_mean[1] = gcpc_pkg::RST_CHROMA_A_MEAN;
        chan_spread[1] = gcpc_pkg::RST_CHROMA_A_SPREAD;
        chan_mean[2] = gcpc_pkg::RST_CHROMA_B_MEAN;
        chan_spread[2] = gcpc_pkg::RST_CHROMA_B_SPREAD;
        ratio_setting = gcpc_pkg::RST_MASK_RATIO;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_for_drain();
            case (phase)
                0: ;
                2: write_all(12'd0, 12'd4095, 12'd0);
                3: begin
                    // Zero spreads act as the smallest spread; the unused index is ignored.
                    write_all(12'd4095, 12'd0, 12'd1024);
                    write_register(CFG_NO_REG, 12'($urandom_range(0, 4095)));
                end
                4: begin
                    write_all({4'($urandom_range(0, 15)), 8'd0}, 12'd1, 12'hFFF);
                    write_register(gcpc_pkg::CFG_CHROMA_A_MEAN,
                                   {8'($urandom_range(0, 255)), 4'd0});
                    write_register(gcpc_pkg::CFG_CHROMA_B_MEAN,
                                   {8'($urandom_range(0, 255)), 4'd0});
                end
                5: begin
                    randomize_setup();
                    write_register(gcpc_pkg::CFG_MASK_RATIO,
                                   {1'b1, 11'($urandom_range(0, 2047))});
                end
                default: randomize_setup();
            endcase
            @(negedge i_clk);
            steady = (phase == NUM_PHASES - 1);
            if (phase == 0) begin
                pixel_backlog.push_back({8'd0, 8'd0, 8'd0});
                pixel_backlog.push_back({8'd255, 8'd255, 8'd255});
                pixel_backlog.push_back({8'd0, 8'd255, 8'd0});
                pixel_backlog.push_back({8'd255, 8'd0, 8'd255});
                pixel_backlog.push_back({8'd220, 8'd128, 8'd128});
                pixel_backlog.push_back({8'd220, 8'd129, 8'd128});
                pixel_backlog.push_back({8'd220, 8'd128, 8'd127});
                pixel_backlog.push_back({8'd215, 8'd128, 8'd128});
                pixel_backlog.push_back({8'd230, 8'd128, 8'd128});
                pixel_backlog.push_back({8'd190, 8'd128, 8'd128});
                pixel_backlog.push_back({8'd250, 8'd128, 8'd128});
                pixel_backlog.push_back({8'd255, 8'd128, 8'd128});
                pixel_backlog.push_back({8'd220, 8'd138, 8'd128});
                pixel_backlog.push_back({8'd220, 8'd118, 8'd128});
                pixel_backlog.push_back({8'd220, 8'd128, 8'd148});
                pixel_backlog.push_back({8'd176, 8'd128, 8'd128});
                pixel_backlog.push_back({8'd177, 8'd128, 8'd128});
                pixel_backlog.push_back({8'd178, 8'd128, 8'd128});
                pixel_backlog.push_back({8'd0, 8'd128, 8'd128});
                pixel_backlog.push_back({8'd220, 8'd0, 8'd255});
            end
            repeat (PIXELS_PER_PHASE) begin
                pixel_backlog.push_back({channel_pick(chan_mean[0], chan_spread[0]),
                                         channel_pick(chan_mean[1], chan_spread[1]),
                                         channel_pick(chan_mean[2], chan_spread[2])});
            end
        end
        wait_for_drain();
        repeat (gcpc_pkg::PIPE_LAT + 4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[gaussian_color_pixel_classifier] OK");
        end else begin
            $display("[gaussian_color_pixel_classifier] ERROR");
        end
        $finish;
    end

    // Pixel driver: every accepted beat is scored with the settings in force.
    always @(posedge i_clk) begin
        if (start && !busy) begin
            pending_scores.push_back(pixel_score({i_light_value, i_chroma_a_value,
                                                  i_chroma_b_value}));
        end
        if (!start || !busy) begin
            if (idle_left > 0) begin
                idle_left--;
                start <= 1'b0;
            end else if (pixel_backlog.size() != 0) begin
                next_pixel = pixel_backlog.pop_front();
                i_light_value <= next_pixel.light;
                i_chroma_a_value <= next_pixel.chroma_a;
                i_chroma_b_value <= next_pixel.chroma_b;
                start <= 1'b1;
                if (!steady && $urandom_range(0, 9) == 0) begin
                    idle_left = $urandom_range(1, 17);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // A result beat holds for the whole cycle, so it is sampled in the middle of it.
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_scores.size() == 0) begin
                report_mismatch("result beat with no pixel outstanding");
            end else begin
                oldest_score = pending_scores.pop_front();
                if (o_white_likelihood !== oldest_score.likelihood) begin
                    report_mismatch($sformatf("likelihood %0d, expected %0d",
                                              o_white_likelihood, oldest_score.likelihood));
                end
                if (o_white_mask !== oldest_score.mask) begin
                    report_mismatch($sformatf("mask %b, expected %b",
                                              o_white_mask, oldest_score.mask));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("[gaussian_color_pixel_classifier] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/gcpc_pkg.sv
rtl/core/gcpc_channel.sv
rtl/core/gaussian_color_pixel_classifier.sv
bench/gaussian_color_pixel_classifier_tb.sv
